// ----- rtl/core/tts_pkg.sv -----
package tts_pkg;

    localparam int SPACE_DEPTH_DEF = 16;
    localparam int SCNT_W          = 9;   // holds a whitespace count up to 511
    localparam int QDEPTH          = 4;
    localparam int OPEN_LEN        = 7;
    localparam int CLOSE_LEN       = 8;

    localparam logic [1:0] OP_DATA    = 2'd0;
    localparam logic [1:0] OP_END     = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    localparam logic [1:0] MODE_UNDEC  = 2'd0;
    localparam logic [1:0] MODE_INSIDE = 2'd1;
    localparam logic [1:0] MODE_PLAIN  = 2'd2;

    localparam logic KIND_CONTENT = 1'b0;
    localparam logic KIND_REASON  = 1'b1;

    localparam logic [7:0] CH_LT = 8'h3C;

    // One unit of back-end work. A write job stores byte at index cnt and
    // releases nothing. A release job sends cnt stored whitespace bytes, then
    // tlen tag bytes, then the byte itself when has_byte is set.
    typedef struct packed {
        logic              wr;
        logic              kind;
        logic              close_sel;
        logic              has_byte;
        logic [7:0]        data;
        logic [SCNT_W-1:0] cnt;
        logic [2:0]        tlen;
    } t_job;

    function automatic logic [7:0] open_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h3C;
            3'd1:    c = 8'h74;
            3'd2:    c = 8'h68;
            3'd3:    c = 8'h69;
            3'd4:    c = 8'h6E;
            3'd5:    c = 8'h6B;
            3'd6:    c = 8'h3E;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] close_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h3C;
            3'd1:    c = 8'h2F;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h68;
            3'd4:    c = 8'h69;
            3'd5:    c = 8'h6E;
            3'd6:    c = 8'h6B;
            default: c = 8'h3E;
        endcase
        return c;
    endfunction

    function automatic logic is_ws(input logic [7:0] b);
        return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
    endfunction

endpackage

// ----- rtl/core/tts_front.sv -----
module tts_front import tts_pkg::*; #(
    parameter int SPACE_DEPTH = SPACE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_data_byte,
    input  logic       i_q_full,
    output logic       o_push,
    output t_job       o_job
);

    localparam int CW = $clog2(SPACE_DEPTH + 1);

    logic [1:0]    r_mode, n_mode;
    logic [2:0]    r_len, n_len;
    logic [CW-1:0] r_scnt, n_scnt;
    logic          push_req;
    logic          fire;

    assign o_ready = !i_q_full;
    assign fire    = i_valid && o_ready;
    assign o_push  = fire && push_req;

    always_comb begin
        n_mode   = r_mode;
        n_len    = r_len;
        n_scnt   = r_scnt;
        push_req = 1'b0;
        o_job    = '0;
        o_job.data = i_data_byte;
        case (i_opcode)
            OP_DATA: begin
                case (r_mode)
                    MODE_UNDEC: begin
                        if (r_len == 3'd0 && is_ws(i_data_byte)) begin
                            push_req  = 1'b1;
                            if (r_scnt < CW'(SPACE_DEPTH)) begin
                                o_job.wr  = 1'b1;
                                o_job.cnt = SCNT_W'(r_scnt);
                                n_scnt    = r_scnt + 1'b1;
                            end else begin
                                // store full: give up on a tag, release as content
                                o_job.kind     = KIND_CONTENT;
                                o_job.cnt      = SCNT_W'(r_scnt);
                                o_job.has_byte = 1'b1;
                                n_mode         = MODE_PLAIN;
                                n_scnt         = '0;
                            end
                        end else if (i_data_byte == open_char(r_len)) begin
                            if (r_len == 3'(OPEN_LEN - 1)) begin
                                n_mode = MODE_INSIDE;
                                n_len  = '0;
                                n_scnt = '0;
                            end else begin
                                n_len = r_len + 1'b1;
                            end
                        end else begin
                            push_req       = 1'b1;
                            o_job.kind     = KIND_CONTENT;
                            o_job.cnt      = SCNT_W'(r_scnt);
                            o_job.tlen     = r_len;
                            o_job.has_byte = 1'b1;
                            n_mode         = MODE_PLAIN;
                            n_len          = '0;
                            n_scnt         = '0;
                        end
                    end
                    MODE_INSIDE: begin
                        if (i_data_byte == close_char(r_len)) begin
                            if (r_len == 3'(CLOSE_LEN - 1)) begin
                                n_mode = MODE_PLAIN;
                                n_len  = '0;
                            end else begin
                                n_len = r_len + 1'b1;
                            end
                        end else begin
                            // '<' occurs only at the head of the close tag, so a
                            // broken prefix can only restart on a new '<'
                            push_req        = 1'b1;
                            o_job.kind      = KIND_REASON;
                            o_job.close_sel = 1'b1;
                            o_job.tlen      = r_len;
                            o_job.has_byte  = (i_data_byte != CH_LT);
                            n_len           = (i_data_byte == CH_LT) ? 3'd1 : 3'd0;
                        end
                    end
                    default: begin
                        push_req       = 1'b1;
                        o_job.kind     = KIND_CONTENT;
                        o_job.has_byte = 1'b1;
                    end
                endcase
            end
            OP_END: begin
                case (r_mode)
                    MODE_UNDEC: begin
                        push_req   = (r_scnt != '0) || (r_len != 3'd0);
                        o_job.kind = KIND_CONTENT;
                        o_job.cnt  = SCNT_W'(r_scnt);
                        o_job.tlen = r_len;
                        n_mode     = MODE_PLAIN;
                        n_len      = '0;
                        n_scnt     = '0;
                    end
                    MODE_INSIDE: begin
                        push_req        = (r_len != 3'd0);
                        o_job.kind      = KIND_REASON;
                        o_job.close_sel = 1'b1;
                        o_job.tlen      = r_len;
                        n_len           = '0;
                    end
                    default: begin
                    end
                endcase
            end
            OP_RESTART: begin
                n_mode = MODE_UNDEC;
                n_len  = '0;
                n_scnt = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_UNDEC;
            r_len  <= '0;
            r_scnt <= '0;
        end else if (fire) begin
            r_mode <= n_mode;
            r_len  <= n_len;
            r_scnt <= n_scnt;
        end
    end

endmodule

// ----- rtl/core/tts_queue.sv -----
module tts_queue import tts_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    output t_job o_job,
    input  logic i_pop
);

    localparam int PW = $clog2(QDEPTH);

    t_job          r_mem [QDEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [PW:0]   r_cnt;

    assign o_full  = (r_cnt == (PW + 1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- rtl/core/tts_back.sv -----
module tts_back import tts_pkg::*; #(
    parameter int SPACE_DEPTH = SPACE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_job       i_job,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output logic       o_kind,
    output logic       o_last
);

    localparam int SAW = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1;
    localparam int TW  = $clog2(SPACE_DEPTH + 9);

    logic [7:0]    r_mem [SPACE_DEPTH];
    logic [7:0]    r_rd;
    logic [TW-1:0] r_idx;
    logic          r_ov, r_sel_mem, r_kind, r_last;
    logic [7:0]    r_byte;

    logic [TW-1:0] cnt_t, tag_end, total;
    logic [2:0]    tag_i;
    logic [7:0]    tag_c;
    logic          in_space, in_tag, is_last, emit, wr;

    assign cnt_t    = TW'(i_job.cnt);
    assign tag_end  = cnt_t + TW'(i_job.tlen);
    assign total    = tag_end + TW'(i_job.has_byte);
    assign in_space = (r_idx < cnt_t);
    assign in_tag   = (r_idx < tag_end);
    assign tag_i    = 3'(r_idx - cnt_t);
    assign tag_c    = i_job.close_sel ? close_char(tag_i) : open_char(tag_i);
    assign is_last  = (r_idx == total - 1'b1);

    assign wr    = i_q_valid && i_job.wr;
    assign emit  = i_q_valid && !i_job.wr && (!r_ov || i_ready);
    assign o_pop = wr || (emit && is_last);

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[i_job.cnt[SAW-1:0]] <= i_job.data;
        end
        if (emit && in_space) begin
            r_rd <= r_mem[r_idx[SAW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_sel_mem <= in_space;
            r_byte    <= in_tag ? tag_c : i_job.data;
            r_kind    <= i_job.kind;
            r_last    <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_idx <= '0;
        end else begin
            if (emit) begin
                r_ov  <= 1'b1;
                r_idx <= is_last ? '0 : r_idx + 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_valid = r_ov;
    assign o_byte  = r_sel_mem ? r_rd : r_byte;
    assign o_kind  = r_kind;
    assign o_last  = r_last;

endmodule

// ----- rtl/core/think_tag_stream_splitter.sv -----
// Splits a text reply into content and reasoning bytes.
// Input stream: one item per byte or command; tuser carries the opcode
// (data, end-of-stream flush, restart), tdata the text byte.
// Output stream: one item per released byte; tuser is the kind (0 content,
// 1 reasoning), tlast marks the last byte released for one input item.
// A leading <think> tag, after optional whitespace, opens reasoning until
// </think>; both tags are dropped. Bytes that may still form a tag are held
// and released later, so one input can release up to SPACE_DEPTH+7 bytes.
// The first byte of a release is registered in the job queue and then in
// the output register before it is presented on the output.
// Throughput: one input item per cycle while the job queue has room; the
// back end emits one byte per cycle while the receiver is ready, and each
// stored leading whitespace byte also occupies the back end for its store write.
// A long release drains at one byte a cycle while the receiver is ready, and
// the four-entry queue then fills and holds the input side off.
// Reset (synchronous, i_rst_n low) returns to the undecided mode with
// nothing held; the output register empties. A stalled receiver holds the
// output item steady and backs the stall up through the queue to o_s_tready.
module think_tag_stream_splitter import tts_pkg::*; #(
    parameter int SPACE_DEPTH = SPACE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] data_byte
    input  logic [1:0] i_s_tuser,   // [1:0] opcode
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic       o_m_tuser,   // [0] out_kind
    output logic       o_m_tlast    // run_last
);

    logic q_full, q_push, q_valid, q_pop;
    t_job f_job, q_job;

    tts_front #(.SPACE_DEPTH(SPACE_DEPTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_opcode    (i_s_tuser),
        .i_data_byte (i_s_tdata),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_job       (f_job)
    );

    tts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (f_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_pop   (q_pop)
    );

    tts_back #(.SPACE_DEPTH(SPACE_DEPTH)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_job     (q_job),
        .o_pop     (q_pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_byte    (o_m_tdata),
        .o_kind    (o_m_tuser),
        .o_last    (o_m_tlast)
    );

endmodule
